// ===== hw/rtl/http_chunked_body_deframer_defines.svh =====
// Assertion macros used by the checker file of the chunked body deframer.
`ifndef HTTP_CHUNKED_BODY_DEFRAMER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DEFRAMER_DEFINES_SVH

// Property that must hold on every enabled clock edge.
`define HCBD_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define HCBD_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HCBD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hcbd_pkg.sv =====
`timescale 1ns / 1ps

package hcbd_pkg;

    // Depth of the token queue between the classifier and the parser.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    typedef enum logic [1:0] {
        PH_SIZE_FIRST = 2'd0,
        PH_SIZE_AFTER = 2'd1,
        PH_PAYLOAD    = 2'd2,
        PH_ENDED      = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_END       = 2'd1,
        KIND_MALFORMED = 2'd2
    } kind_t;

    // One classified input byte.
    typedef struct packed {
        logic       is_lf;
        logic       is_cr;
        logic       is_hex;
        logic [3:0] digit;
        logic [7:0] data;
    } tok_t;

endpackage

// ===== hw/rtl/http_chunked_body_deframer.sv =====
// Channel   Handshake          Payload                         Direction
// input     push / full        data_byte[7:0]                  into block
// result    empty / pop        payload_byte[7:0], kind[1:0],   out of block
//                              is_last
//
// One byte is taken per cycle while full is low, and one result can be delivered per cycle.
// A pushed byte shows its result, if any, after it has passed the head register
// of the token queue and then the result register of the parser.
// Reset empties the queue and clears the parser state and the valid flag of the
// result register; there is no clearing pass, so a push is accepted as soon as reset is released.
// A stalled result side holds the parser, and the four-entry queue absorbs
// bytes until full rises.
`timescale 1ns / 1ps

module http_chunked_body_deframer #(
    parameter int SIZE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] payload_byte,
    output logic [1:0] kind,
    output logic       is_last
);
    import hcbd_pkg::*;

    // The front part classifies each raw byte into a token: line feed,
    // carriage return, hex digit with its value, or anything else.
    tok_t in_tok;
    tok_t q_tok;
    logic q_valid;
    logic q_pop;
    logic q_push;

    assign q_push = push && !full;

    hcbd_front u_front (
        .data_byte (data_byte),
        .tok       (in_tok)
    );

    // The queue decouples byte intake from the parser, so a stalled result
    // side does not immediately stall the byte source.
    hcbd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_tok (in_tok),
        .full   (full),
        .rd_en  (q_pop),
        .rd_tok (q_tok),
        .valid  (q_valid)
    );

    // The back part runs the size-line and payload state machine, one token
    // per transaction, and holds the oldest result until it is popped. After
    // the stream ends it keeps draining tokens without producing results.
    hcbd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (q_valid),
        .tok          (q_tok),
        .tok_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .payload_byte (payload_byte),
        .kind         (kind),
        .is_last      (is_last)
    );

endmodule

// ===== hw/rtl/hcbd_front.sv =====
`timescale 1ns / 1ps

module hcbd_front (
    input  logic [7:0]    data_byte,
    output hcbd_pkg::tok_t tok
);
    import hcbd_pkg::*;

    logic [7:0] off_num;
    logic [7:0] off_low;
    logic [7:0] off_up;

    assign off_num = data_byte - 8'h30;
    assign off_low = data_byte - 8'h57;
    assign off_up  = data_byte - 8'h37;

    always_comb
    begin
        tok.is_lf  = (data_byte == CHAR_LF);
        tok.is_cr  = (data_byte == CHAR_CR);
        tok.data   = data_byte;
        tok.is_hex = 1'b1;
        case (data_byte) inside
            [8'h30:8'h39]: tok.digit = off_num[3:0];
            [8'h61:8'h66]: tok.digit = off_low[3:0];
            [8'h41:8'h46]: tok.digit = off_up[3:0];
            default:
            begin
                tok.digit  = 4'd0;
                tok.is_hex = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/hcbd_queue.sv =====
`timescale 1ns / 1ps

module hcbd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  hcbd_pkg::tok_t wr_tok,
    output logic           full,
    input  logic           rd_en,
    output hcbd_pkg::tok_t rd_tok,
    output logic           valid
);
    import hcbd_pkg::*;

    tok_t              mem [QDEPTH];
    tok_t              rd_tok_reg;
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;

    assign full   = (count_reg == QCNT_W'(QDEPTH));
    assign valid  = (count_reg != '0);
    assign rd_tok = rd_tok_reg;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // The head entry is kept in a register. When the entry that becomes the
    // head is being written in the same cycle, the incoming token is taken.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_tok;
        end
        if (wr_en && (wr_ptr_reg == rd_ptr_next))
        begin
            rd_tok_reg <= wr_tok;
        end
        else
        begin
            rd_tok_reg <= mem[rd_ptr_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/hcbd_back.sv =====
`timescale 1ns / 1ps

module hcbd_back #(
    parameter int SIZE_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tok_valid,
    input  hcbd_pkg::tok_t tok,
    output logic           tok_pop,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     payload_byte,
    output logic [1:0]     kind,
    output logic           is_last
);
    import hcbd_pkg::*;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [SIZE_BITS-1:0] accum_reg;
    logic [SIZE_BITS-1:0] accum_next;
    logic [SIZE_BITS-1:0] rem_reg;
    logic [SIZE_BITS-1:0] rem_next;
    logic                 nonempty_reg;
    logic                 nonempty_next;
    logic                 cr_reg;
    logic                 cr_next;
    logic                 bad_reg;
    logic                 bad_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_byte_reg;
    logic [7:0]           out_byte_next;
    kind_t                out_kind_reg;
    kind_t                out_kind_next;
    logic                 out_last_reg;
    logic                 out_last_next;

    logic                 out_ready;
    logic                 has_res;
    logic [7:0]           res_byte;
    kind_t                res_kind;
    logic                 res_last;
    logic                 clear_line;

    // The result register takes a new transaction when it is free or being drained.
    assign out_ready    = !out_valid_reg || pop;
    assign tok_pop      = tok_valid && out_ready;
    assign empty        = !out_valid_reg;
    assign payload_byte = out_byte_reg;
    assign kind         = out_kind_reg;
    assign is_last      = out_last_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        rem_next      = rem_reg;
        nonempty_next = nonempty_reg;
        cr_next       = cr_reg;
        bad_next      = bad_reg;
        has_res       = 1'b0;
        res_byte      = 8'd0;
        res_kind      = KIND_PAYLOAD;
        res_last      = 1'b0;
        clear_line    = 1'b0;

        case (phase_reg)
            PH_ENDED:
            begin
                has_res = 1'b0;
            end
            PH_PAYLOAD:
            begin
                if (rem_reg == '0)
                begin
                    phase_next = PH_SIZE_FIRST;
                    clear_line = 1'b1;
                end
                else
                begin
                    rem_next = rem_reg - SIZE_BITS'(1);
                    if (rem_reg == SIZE_BITS'(1))
                    begin
                        phase_next = PH_SIZE_FIRST;
                        clear_line = 1'b1;
                    end
                    has_res  = 1'b1;
                    res_byte = tok.data;
                end
            end
            default:
            begin
                if (tok.is_lf)
                begin
                    clear_line = 1'b1;
                    if (!nonempty_reg && phase_reg == PH_SIZE_FIRST)
                    begin
                        phase_next = PH_SIZE_AFTER;
                    end
                    else if (!nonempty_reg || bad_reg)
                    begin
                        phase_next = PH_ENDED;
                        has_res    = 1'b1;
                        res_kind   = KIND_MALFORMED;
                        res_last   = 1'b1;
                    end
                    else if (accum_reg == '0)
                    begin
                        phase_next = PH_ENDED;
                        has_res    = 1'b1;
                        res_kind   = KIND_END;
                        res_last   = 1'b1;
                    end
                    else
                    begin
                        rem_next   = accum_reg;
                        phase_next = PH_PAYLOAD;
                    end
                end
                else
                begin
                    // A CR that is not followed directly by LF spoils the line.
                    bad_next      = bad_reg | cr_reg;
                    nonempty_next = nonempty_reg | cr_reg;
                    cr_next       = 1'b0;
                    if (tok.is_cr)
                    begin
                        cr_next = 1'b1;
                    end
                    else
                    begin
                        nonempty_next = 1'b1;
                        if (!tok.is_hex || accum_reg[SIZE_BITS-1 -: 4] != 4'd0)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            accum_next = {accum_reg[SIZE_BITS-5:0], tok.digit};
                        end
                    end
                end
            end
        endcase

        if (clear_line)
        begin
            accum_next    = '0;
            nonempty_next = 1'b0;
            cr_next       = 1'b0;
            bad_next      = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        if (tok_pop)
        begin
            out_valid_next = has_res;
            out_byte_next  = res_byte;
            out_kind_next  = res_kind;
            out_last_next  = res_last;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIZE_FIRST;
            accum_reg     <= '0;
            rem_reg       <= '0;
            nonempty_reg  <= 1'b0;
            cr_reg        <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (tok_pop)
            begin
                phase_reg    <= phase_next;
                accum_reg    <= accum_next;
                rem_reg      <= rem_next;
                nonempty_reg <= nonempty_next;
                cr_reg       <= cr_next;
                bad_reg      <= bad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ===== hw/rtl/hcbd_checker.sv =====
`timescale 1ns / 1ps
`include "http_chunked_body_deframer_defines.svh"

module hcbd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic [7:0] data_byte,
    input logic       empty,
    input logic       pop,
    input logic [7:0] payload_byte,
    input logic [1:0] kind,
    input logic       is_last
);
    import hcbd_pkg::*;

    logic ended_reg;
    logic ended_next;

    // Set once the stream-ending result has been taken.
    assign ended_next = ended_reg || (pop && !empty && is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ended_reg <= 1'b0;
        end
        else
        begin
            ended_reg <= ended_next;
        end
    end

    `HCBD_ASSERT_IMPLY(a_no_result_after_end, clk, rst_n, ended_reg, empty, "result after stream end")
    `HCBD_ASSERT_IMPLY(a_last_matches_kind, clk, rst_n, !empty, (is_last == (kind != KIND_PAYLOAD)) && (kind != 2'd3), "is_last and kind disagree")
    `HCBD_ASSERT_IMPLY(a_zero_byte_on_end, clk, rst_n, !empty && (kind != KIND_PAYLOAD), payload_byte == 8'd0, "nonzero byte on end result")
    `HCBD_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(payload_byte) && $stable(kind) && $stable(is_last), "waiting result changed")

endmodule

bind http_chunked_body_deframer hcbd_checker u_hcbd_checker (.*);
